>>> hdl/fixed_width_histogram_top_assert.svh
// Assertion macros for the fixed-width histogram top level.
// Expects clk_i and rst_ni in the including module's scope.
`ifndef FIXED_WIDTH_HISTOGRAM_TOP_ASSERT_SVH
`define FIXED_WIDTH_HISTOGRAM_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FWH_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fwh assertion failed");

// Next-cycle implication, disabled during reset.
`define FWH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fwh assertion failed");

`endif

>>> hdl/fwh_pkg.sv
// Shared constants and codes for the fixed-width histogram.
// No dependencies; used by fwh_div and fixed_width_histogram_top.
package fwh_pkg;

  localparam int MAX_BINS    = 62;
  localparam int COUNT_BITS  = 32;
  localparam int STORE_DEPTH = MAX_BINS + 2;
  localparam int BIN_W       = $clog2(STORE_DEPTH);
  localparam int EFF_MAX     = (MAX_BINS < 62) ? MAX_BINS : 62;

  localparam int SAMPLE_W = 32;
  localparam int WIDTH_W  = 31;
  localparam int NBINS_W  = 6;
  localparam int OP_W     = 2;
  localparam int IDX_W    = 6;
  localparam int COUNT_W  = 32;

  localparam int DVD_W  = SAMPLE_W;
  localparam int DVS_W  = WIDTH_W;
  localparam int STEP_W = $clog2(DVD_W);

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 40;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_START = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_NBINS = 2'd2;

  localparam logic [SAMPLE_W-1:0] START_RST = 32'd0;
  localparam logic [WIDTH_W-1:0]  WIDTH_RST = 31'd65536;
  localparam logic [NBINS_W-1:0]  NBINS_RST = 6'd16;

endpackage

>>> hdl/fwh_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on fwh_pkg for operand widths.
module fwh_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [fwh_pkg::DVD_W-1:0]   dividend_i,
  input  logic [fwh_pkg::DVS_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [fwh_pkg::DVD_W-1:0]   quotient_o
);
  import fwh_pkg::*;

  logic              busy_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DVD_W-1:0]  quo_q;

  logic [DVS_W:0]    rem_sh;
  logic [DVS_W+1:0]  trial;
  logic              qbit;

  // Shift in the next dividend bit, try to subtract the divisor.
  assign rem_sh = {rem_q, quo_q[DVD_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, divisor_i};
  assign qbit   = ~trial[DVS_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(DVD_W - 1);
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= qbit ? trial[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], qbit};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> hdl/fixed_width_histogram_top.sv
// Top level of the fixed-width histogram: stream ports, APB registers,
// sequencer and count store. Depends on fwh_pkg, fwh_div and the assert header.

// Fixed-width histogram with an underflow bin (0), regular bins 1..num_bins
// and an overflow bin (num_bins+1). One input word carries an op in tuser:
// add a signed Q16.16 sample, read the count of one bin, or clear all counts.
// Every input word produces exactly one result word. An add finds its bin as
// floor((sample-bin_start)/bin_width)+1 with a 32-step radix-2 divider, then
// does a read-modify-write of the count store. An add at or above bin_start
// goes through decode, the divider, the store read, the modify step and the
// output state; an add below bin_start or an in-range read skips the divider;
// an out-of-range read, a clear or an unused op goes from decode to output. A
// result that finds the output register still full waits there until it frees.
// The input side is ready only between items; a finished result waits in an
// output register, so the next item may be accepted while it is pending.
// Counts saturate at all ones. Reset and clear zero every count at once
// through per-entry valid bits, so no clearing pass follows reset. A bin_width
// of zero acts as one; num_bins of zero acts as one and is capped at 62.
// Registers (APB, byte address): 0x0 bin_start, 0x4 bin_width, 0x8 num_bins.
// Write registers only while the block is idle.
module fixed_width_histogram_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // sample [31:0], bin_index [37:32], zero pad [39:38]
  input  logic [fwh_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // op [1:0]
  input  logic [fwh_pkg::OP_W-1:0]        s_axis_tuser,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // bin [5:0], count [37:6], zero pad [39:38]
  output logic [fwh_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // index_error [0]
  output logic [0:0]                      m_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fwh_pkg::PADDR_W-1:0]     paddr,
  input  logic [fwh_pkg::PDATA_W-1:0]     pwdata,
  output logic [fwh_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);
  import fwh_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_MOD    = 3'd4;
  localparam logic [2:0] ST_OUT    = 3'd5;

  // ---------------- configuration registers ----------------
  logic [SAMPLE_W-1:0]  start_q;
  logic [WIDTH_W-1:0]   width_q;
  logic [NBINS_W-1:0]   nbins_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= START_RST;
      width_q <= WIDTH_RST;
      nbins_q <= NBINS_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_START: start_q <= pwdata;
        REG_WIDTH: width_q <= pwdata[WIDTH_W-1:0];
        REG_NBINS: nbins_q <= pwdata[NBINS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_START: prdata = start_q;
      REG_WIDTH: prdata = PDATA_W'(width_q);
      REG_NBINS: prdata = PDATA_W'(nbins_q);
      default:   prdata = '0;
    endcase
  end

  // Effective bin count and overflow bin index.
  logic [NBINS_W-1:0] eff_bins;
  logic [BIN_W-1:0]   last_bin;
  logic [WIDTH_W-1:0] divisor;

  always_comb begin
    eff_bins = nbins_q;
    if (eff_bins == '0) eff_bins = NBINS_W'(1);
    if (eff_bins > NBINS_W'(EFF_MAX)) eff_bins = NBINS_W'(EFF_MAX);
  end
  assign last_bin = BIN_W'(eff_bins) + 1'b1;
  assign divisor  = (width_q == '0) ? WIDTH_W'(1) : width_q;

  // ---------------- sequencer state ----------------
  logic [2:0]          state_q, state_d;
  logic [OP_W-1:0]     op_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic [IDX_W-1:0]    index_q;
  logic [BIN_W-1:0]    bin_q, bin_d;
  logic [COUNT_W-1:0]  cnt_q, cnt_d;
  logic                err_q, err_d;
  logic [STORE_DEPTH-1:0] valid_q, valid_d;

  logic                m_valid_q, m_valid_d;
  logic [BIN_W-1:0]    m_bin_q;
  logic [COUNT_W-1:0]  m_cnt_q;
  logic                m_err_q;
  logic                m_load;

  logic                accept;
  logic [SAMPLE_W:0]   diff;
  logic                div_start, div_done;
  logic [DVD_W-1:0]    quotient;

  logic [COUNT_BITS-1:0] mem [STORE_DEPTH];
  logic [COUNT_BITS-1:0] rd_q;
  logic [COUNT_BITS-1:0] cur_cnt, new_cnt;
  logic                  mem_we;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Sign-extended difference; its top bit marks an underflow sample.
  assign diff = {sample_q[SAMPLE_W-1], sample_q} - {start_q[SAMPLE_W-1], start_q};

  fwh_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (diff[DVD_W-1:0]),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Entry not yet written since reset or clear reads as zero.
  assign cur_cnt = valid_q[bin_q] ? rd_q : '0;
  assign new_cnt = (&cur_cnt) ? cur_cnt : cur_cnt + 1'b1;

  always_comb begin
    state_d   = state_q;
    bin_d     = bin_q;
    cnt_d     = cnt_q;
    err_d     = err_q;
    valid_d   = valid_q;
    div_start = 1'b0;
    mem_we    = 1'b0;
    m_load    = 1'b0;
    m_valid_d = m_valid_q;
    if (m_valid_q && m_axis_tready) m_valid_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        cnt_d = '0;
        err_d = 1'b0;
        bin_d = '0;
        case (op_q)
          OP_ADD: begin
            if (diff[SAMPLE_W]) begin
              state_d = ST_READ;
            end else begin
              div_start = 1'b1;
              state_d   = ST_DIV;
            end
          end
          OP_READ: begin
            bin_d = BIN_W'(index_q);
            if ({1'b0, index_q} > (IDX_W + 1)'(last_bin)) begin
              err_d   = 1'b1;
              state_d = ST_OUT;
            end else begin
              state_d = ST_READ;
            end
          end
          OP_CLEAR: begin
            valid_d = '0;
            state_d = ST_OUT;
          end
          default: state_d = ST_OUT;
        endcase
      end
      ST_DIV: begin
        // Clamp quotient+1 to the overflow bin.
        if (div_done) begin
          if (quotient >= DVD_W'(last_bin)) bin_d = last_bin;
          else                              bin_d = BIN_W'(quotient) + 1'b1;
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_MOD;
      ST_MOD: begin
        if (op_q == OP_ADD) begin
          mem_we         = 1'b1;
          valid_d[bin_q] = 1'b1;
          cnt_d          = COUNT_W'(new_cnt);
        end else begin
          cnt_d = COUNT_W'(cur_cnt);
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // Hold until the output register is free.
        if (!m_valid_q || m_axis_tready) begin
          m_load    = 1'b1;
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      valid_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= s_axis_tuser;
      sample_q <= s_axis_tdata[SAMPLE_W-1:0];
      index_q  <= s_axis_tdata[SAMPLE_W+IDX_W-1:SAMPLE_W];
    end
    bin_q <= bin_d;
    cnt_q <= cnt_d;
    err_q <= err_d;
    if (m_load) begin
      m_bin_q <= bin_q;
      m_cnt_q <= cnt_q;
      m_err_q <= err_q;
    end
  end

  // Count store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[bin_q] <= new_cnt;
    rd_q <= mem[bin_q];
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = {(M_TDATA_W - COUNT_W - IDX_W)'(0), m_cnt_q, IDX_W'(m_bin_q)};
  assign m_axis_tuser[0] = m_err_q;

  // ---------------- assertions ----------------
  `include "fixed_width_histogram_top_assert.svh"

  `FWH_ASSERT_IMPL(a_div_done_in_div, div_done, state_q == ST_DIV)
  `FWH_ASSERT_IMPL(a_err_zero_count, m_valid_q && m_err_q, m_cnt_q == '0)
  `FWH_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

>>> sim/fixed_width_histogram_top_test.sv
// Self-checking testbench for fixed_width_histogram_top: stream words in, one count word out.
// Needs fwh_pkg and the histogram RTL only; expected words come from an in-bench predictor.
// Walks a directed table first, then random phases under several register settings.
module fixed_width_histogram_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fwh_pkg::*;

  // Op code that the block must treat as a no-op.
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASES      = 7;
  localparam int PHASE_WORDS = 250;

  // One result word: bin, count, index error.
  typedef struct packed {
    logic [IDX_W-1:0]   bin;
    logic [COUNT_W-1:0] count;
    logic               err;
  } count_word_t;

  // One row of the directed table: either a register write or a stream word.
  typedef struct packed {
    logic                 is_cfg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [31:0]          value;   // register value, or the sample of a word
    logic [OP_W-1:0]      op;
    logic [IDX_W-1:0]     idx;
    logic                 typed;   // expectation typed in the row
    count_word_t          want;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic [S_TDATA_W-1:0]  s_axis_tdata;
  logic [OP_W-1:0]       s_axis_tuser;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [PDATA_W-1:0]    pwdata;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  fixed_width_histogram_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Predictor state: its own copy of the count store and the registers.
  logic [COUNT_W-1:0]  hist_counts [STORE_DEPTH];
  logic [SAMPLE_W-1:0] cfg_start = START_RST;
  logic [WIDTH_W-1:0]  cfg_width = WIDTH_RST;
  logic [NBINS_W-1:0]  cfg_nbins = NBINS_RST;

  // Count words still owed by the block, oldest first.
  count_word_t awaited_counts [$];
  count_word_t want_word;

  // Directed stimulus table.
  dir_row_t dir_rows [$];

  int fail_count    = 0;
  int cycle_count   = 0;
  int src_idle_pct  = 0;   // chance in 100 that the sender skips a cycle
  int snk_stall_pct = 0;   // chance in 100 that the receiver stalls a cycle

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Regular bin count as the block sees it: zero acts as one, capped.
  function automatic int eff_nbins();
    int n;
    n = cfg_nbins;
    if (n == 0) n = 1;
    if (n > MAX_BINS) n = MAX_BINS;
    if (n > EFF_MAX) n = EFF_MAX;
    return n;
  endfunction

  // Underflow below start, else floor((s-start)/width)+1 clamped to overflow.
  function automatic logic [IDX_W-1:0] bin_of_sample(input logic [SAMPLE_W-1:0] sample);
    longint          s;
    longint          st;
    longint unsigned w;
    longint unsigned q;
    s  = $signed(sample);
    st = $signed(cfg_start);
    w  = (cfg_width == '0) ? 1 : cfg_width;
    if (s < st) return '0;
    q = s - st;
    q = q / w + 1;
    if (q > eff_nbins() + 1) q = eff_nbins() + 1;
    return q[IDX_W-1:0];
  endfunction

  // Apply one accepted word to the predictor and return the count word it owes.
  function automatic count_word_t tally_word(input logic [OP_W-1:0] op,
                                             input logic [SAMPLE_W-1:0] sample,
                                             input logic [IDX_W-1:0] idx);
    count_word_t r;
    r = '0;
    case (op)
      OP_ADD: begin
        r.bin = bin_of_sample(sample);
        // saturate: a full counter stays full
        if (hist_counts[r.bin] != '1) hist_counts[r.bin]++;
        r.count = hist_counts[r.bin];
      end
      OP_READ: begin
        r.bin = idx;
        if (idx > eff_nbins() + 1) r.err = 1'b1;
        else r.count = hist_counts[idx];
      end
      OP_CLEAR: begin
        foreach (hist_counts[i]) hist_counts[i] = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset, timeout
  // ---------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Kill the run if it hangs; the limit is far above the slowest legal run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("fixed_width_histogram_top test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, then check every accepted word
  // ---------------------------------------------------------------------------

  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Sample right after the edge: every signal still holds its pre-edge value.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_counts.size() == 0) begin
        $error("count word with nothing awaited: bin %0d count %0d index_error %0d",
               m_axis_tdata[5:0], m_axis_tdata[37:6], m_axis_tuser[0]);
        fail_count++;
      end else begin
        want_word = awaited_counts.pop_front();
        if (m_axis_tdata[5:0] !== want_word.bin) begin
          $error("bin: expected %0d, got %0d", want_word.bin, m_axis_tdata[5:0]);
          fail_count++;
        end
        if (m_axis_tdata[37:6] !== want_word.count) begin
          $error("count: expected %0d, got %0d", want_word.count, m_axis_tdata[37:6]);
          fail_count++;
        end
        if (m_axis_tuser[0] !== want_word.err) begin
          $error("index_error: expected %0d, got %0d", want_word.err, m_axis_tuser[0]);
          fail_count++;
        end
        if (m_axis_tdata[39:38] !== 2'b00) begin
          $error("tdata pad: expected 0, got %0d", m_axis_tdata[39:38]);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender and register port
  // ---------------------------------------------------------------------------

  // Offer one word, then predict it at the edge that accepts it. Valid is lowered
  // only while the sender idles, so back-to-back words keep it high without a glitch.
  task automatic push_word(input logic [OP_W-1:0] op, input logic [SAMPLE_W-1:0] sample,
                           input logic [IDX_W-1:0] idx, input logic typed,
                           input count_word_t want);
    count_word_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, idx, sample};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = tally_word(op, sample, idx);
    awaited_counts.insert(awaited_counts.size(), typed ? want : pred);
  endtask

  // Drop valid and hold until every owed word has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (awaited_counts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write one register (setup + access), read it back, then mirror it.
  task automatic write_reg(input logic [REG_IDX_W-1:0] ridx, input logic [31:0] val);
    logic [31:0] mask;
    case (ridx)
      REG_WIDTH: mask = {1'b0, {WIDTH_W{1'b1}}};
      REG_NBINS: mask = {{(32-NBINS_W){1'b0}}, {NBINS_W{1'b1}}};
      default:   mask = '1;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ridx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== (val & mask)) begin
      $error("register %0d readback: expected %0h, got %0h", ridx, val & mask, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    case (ridx)
      REG_START: cfg_start = val;
      REG_WIDTH: cfg_width = val[WIDTH_W-1:0];
      REG_NBINS: cfg_nbins = val[NBINS_W-1:0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Append one row to the directed table.
  function automatic void add_row(input dir_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic dir_row_t cfg_row(input logic [REG_IDX_W-1:0] ridx, input logic [31:0] val);
    dir_row_t r;
    r = '0;
    r.is_cfg  = 1'b1;
    r.reg_idx = ridx;
    r.value   = val;
    return r;
  endfunction

  function automatic dir_row_t word_row(input logic [OP_W-1:0] op, input logic [31:0] sample,
                                        input logic [IDX_W-1:0] idx);
    dir_row_t r;
    r = '0;
    r.op    = op;
    r.value = sample;
    r.idx   = idx;
    return r;
  endfunction

  function automatic dir_row_t chk_row(input logic [OP_W-1:0] op, input logic [31:0] sample,
                                       input logic [IDX_W-1:0] idx, input logic [IDX_W-1:0] bin,
                                       input logic [COUNT_W-1:0] cnt, input logic err);
    dir_row_t r;
    r = word_row(op, sample, idx);
    r.typed      = 1'b1;
    r.want.bin   = bin;
    r.want.count = cnt;
    r.want.err   = err;
    return r;
  endfunction

  // Sample for an add: mostly aimed at a chosen bin (inside or on its edges),
  // the rest fully random or at the extremes of the field and the range.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    longint v;
    longint w;
    int     k;
    int     pick;
    w    = (cfg_width == '0) ? 1 : cfg_width;
    pick = $urandom_range(99);
    k    = $urandom_range(eff_nbins() + 1);
    if (pick < 20) return $urandom;
    if (pick < 35) begin
      case ($urandom_range(3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return cfg_start;
        default: return cfg_start - 1;
      endcase
    end
    v = $signed(cfg_start) + (k - 1) * w;
    if (pick < 50) v = v + (pick[0] ? w - 1 : 0);
    else v = v + $urandom_range(w - 1);
    if (v < -(64'sd2147483648)) v = -(64'sd2147483648);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    return v[31:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int       pick;
    logic [IDX_W-1:0] ridx;

    foreach (hist_counts[i]) hist_counts[i] = '0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_ADD;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. Registers start at reset: start 0, width 1.0, 16 bins,
    // so the overflow bin is 17.
    add_row(chk_row(OP_READ,  32'h0,         6'd5,  6'd5,  32'd0, 1'b0));
    add_row(chk_row(OP_READ,  32'h0,         6'd17, 6'd17, 32'd0, 1'b0));
    add_row(chk_row(OP_READ,  32'h0,         6'd18, 6'd18, 32'd0, 1'b1));
    add_row(chk_row(OP_READ,  32'hFFFF_FFFF, 6'd63, 6'd63, 32'd0, 1'b1));
    add_row(chk_row(OP_ADD,   32'h0000_0000, 6'd63, 6'd1,  32'd1, 1'b0));
    add_row(chk_row(OP_ADD,   32'hFFFF_FFFF, 6'd0,  6'd0,  32'd1, 1'b0));
    add_row(chk_row(OP_ADD,   32'h8000_0000, 6'd0,  6'd0,  32'd2, 1'b0));
    add_row(chk_row(OP_ADD,   32'h7FFF_FFFF, 6'd0,  6'd17, 32'd1, 1'b0));
    add_row(chk_row(OP_ADD,   32'h0001_0000, 6'd0,  6'd2,  32'd1, 1'b0));
    add_row(chk_row(OP_ADD,   32'h000F_FFFF, 6'd0,  6'd16, 32'd1, 1'b0));
    add_row(chk_row(OP_ADD,   32'h0010_0000, 6'd0,  6'd17, 32'd2, 1'b0));
    add_row(chk_row(OP_READ,  32'h0,         6'd17, 6'd17, 32'd2, 1'b0));
    // unused op: nothing changes, all-zero word
    add_row(chk_row(OP_NONE,  32'hDEAD_BEEF, 6'd42, 6'd0,  32'd0, 1'b0));
    add_row(chk_row(OP_CLEAR, 32'hFFFF_FFFF, 6'd63, 6'd0,  32'd0, 1'b0));
    add_row(chk_row(OP_READ,  32'h0,         6'd0,  6'd0,  32'd0, 1'b0));
    add_row(word_row(OP_ADD,  32'h0000_8000, 6'd0));
    // zero width acts as one
    add_row(cfg_row(REG_WIDTH, 32'h0));
    add_row(word_row(OP_ADD,  32'h0000_0005, 6'd0));
    // zero bins acts as one: overflow bin is 2, counts above it are kept
    add_row(cfg_row(REG_NBINS, 32'h0));
    add_row(word_row(OP_ADD,  32'h0000_0064, 6'd0));
    add_row(chk_row(OP_READ,  32'h0,         6'd3,  6'd3,  32'd0, 1'b1));
    add_row(chk_row(OP_READ,  32'h0,         6'd6,  6'd6,  32'd0, 1'b1));
    // 63 bins caps at 62: the held count in bin 6 shows again
    add_row(cfg_row(REG_NBINS, 32'h3F));
    add_row(word_row(OP_READ, 32'h0,         6'd6));
    add_row(word_row(OP_ADD,  32'h7FFF_FFFF, 6'd0));
    add_row(cfg_row(REG_START, 32'h8000_0000));
    add_row(word_row(OP_ADD,  32'h8000_0000, 6'd0));
    add_row(word_row(OP_READ, 32'h0,         6'd63));
    add_row(cfg_row(REG_START, 32'h7FFF_FFFF));
    add_row(cfg_row(REG_WIDTH, 32'h7FFF_FFFF));
    add_row(cfg_row(REG_NBINS, 32'h1));
    add_row(word_row(OP_ADD,  32'h7FFF_FFFF, 6'd0));
    add_row(word_row(OP_ADD,  32'h7FFF_FFFE, 6'd0));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        drain();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
      end else begin
        push_word(dir_rows[i].op, dir_rows[i].value, dir_rows[i].idx,
                  dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random phases: new registers each phase, idling mode cycles through
    // none, sender only, receiver only, both.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph % 4)
        0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1:       begin src_idle_pct = 56; snk_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  snk_stall_pct = 56; end
        default: begin src_idle_pct = 33; snk_stall_pct = 33; end
      endcase
      case (ph)
        0: begin
          write_reg(REG_START, 32'hFFF8_0000);   // -8.0
          write_reg(REG_WIDTH, 32'h0000_8000);   // 0.5
          write_reg(REG_NBINS, 32'd32);
        end
        1: begin
          write_reg(REG_START, 32'h8000_0000);
          write_reg(REG_WIDTH, 32'h7FFF_FFFF);
          write_reg(REG_NBINS, 32'd62);
        end
        2: begin
          write_reg(REG_START, 32'h7FFF_FFFF);
          write_reg(REG_WIDTH, 32'h1);
          write_reg(REG_NBINS, 32'd1);
        end
        3: begin
          write_reg(REG_START, $urandom_range(255) - 128);
          write_reg(REG_WIDTH, $urandom_range(4, 1));
          write_reg(REG_NBINS, 32'd63);
        end
        4: begin
          write_reg(REG_START, $urandom);
          write_reg(REG_WIDTH, 32'h0);
          write_reg(REG_NBINS, 32'h0);
        end
        5: begin
          write_reg(REG_START, $urandom);
          write_reg(REG_WIDTH, $urandom);
          write_reg(REG_NBINS, $urandom_range(63));
        end
        default: begin
          write_reg(REG_START, START_RST);
          write_reg(REG_WIDTH, WIDTH_RST);
          write_reg(REG_NBINS, NBINS_RST);
        end
      endcase

      for (int n = 0; n < PHASE_WORDS; n++) begin
        pick = $urandom_range(99);
        // reads mostly hit live bins, sometimes anywhere in the index field
        ridx = ($urandom_range(99) < 85) ? IDX_W'($urandom_range(eff_nbins() + 1))
                                         : IDX_W'($urandom_range(63));
        if (pick < 62)      push_word(OP_ADD,   pick_sample(), IDX_W'($urandom), 1'b0, '0);
        else if (pick < 92) push_word(OP_READ,  $urandom,      ridx,             1'b0, '0);
        else if (pick < 94) push_word(OP_CLEAR, $urandom,      IDX_W'($urandom), 1'b0, '0);
        else                push_word(OP_NONE,  $urandom,      IDX_W'($urandom), 1'b0, '0);
      end
    end

    // Let the last words drain, then give stray words time to show up.
    drain();
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("fixed_width_histogram_top test passed");
    end else begin
      $display("fixed_width_histogram_top test failed");
    end
    $finish;
  end

endmodule

>>> fixed_width_histogram_top.f
+incdir+hdl
hdl/fwh_pkg.sv
hdl/fwh_div.sv
hdl/fixed_width_histogram_top.sv
sim/fixed_width_histogram_top_test.sv
